// ===== design/etf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// epoch timestamp formatter package
// item types shared by the conversion pipeline, the character serialiser and
// the top level
// ---------------------------------------------------------------------------
package etf_pkg;

   // command codes
   localparam logic CmdDateTime = 1'b0;
   localparam logic CmdTimeOnly = 1'b1;

   typedef struct packed {
      logic        command;
      logic [31:0] epoch_seconds;
   } req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       last;
   } rsp_type;

   // decimal digits of one converted timestamp
   typedef struct packed {
      logic       command;
      logic [3:0] day_hi;
      logic [3:0] day_lo;
      logic [3:0] mon_hi;
      logic [3:0] mon_lo;
      logic [3:0] yr_3;
      logic [3:0] yr_2;
      logic [3:0] yr_1;
      logic [3:0] yr_0;
      logic [3:0] hr_hi;
      logic [3:0] hr_lo;
      logic [3:0] min_hi;
      logic [3:0] min_lo;
      logic [3:0] sec_hi;
      logic [3:0] sec_lo;
   } date_digits_type;

endpackage
`default_nettype wire

// ===== design/etf_date_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// etf date pipeline
// seventeen-stage conversion of epoch seconds into decimal date and time
// digits; constant divisions by reciprocal multiply and one correction step
// ---------------------------------------------------------------------------
module etf_date_pipe (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_stall,
   input  wire etf_pkg::req_type         in_item,
   output logic                          out_valid,
   input  wire logic                     out_stall,
   output etf_pkg::date_digits_type      out_item
);

   localparam int unsigned NumStages = 17;

   // floor reciprocals: the estimate is exact or one short
   localparam logic [28:0] M225  = 29'd305419896;  // 2^36 / 225
   localparam logic [18:0] M3    = 19'd349525;     // 2^20 / 3
   localparam logic [6:0]  M15   = 7'd68;          // 2^10 / 15
   localparam logic [8:0]  M365A = 9'd359;         // 2^17 / 365
   localparam logic [9:0]  M365B = 10'd718;        // 2^18 / 365
   localparam logic [3:0]  M153  = 4'd13;          // 2^11 / 153

   localparam logic [19:0] EpochShift = 20'd719468;
   localparam logic [19:0] Era5Start  = 20'd730485;
   localparam logic [19:0] Era4Start  = 20'd584388;

   typedef struct packed {
      logic        cmd;
      logic [27:0] x28;
      logic [3:0]  lo4;
      logic [20:0] hq;
      logic [11:0] ms;
      logic [15:0] dq;
      logic [5:0]  msq;
      logic [15:0] days;
      logic [4:0]  hh;
      logic [5:0]  mm;
      logic [5:0]  ss;
      logic        era5;
      logic [17:0] doe;
      logic [6:0]  q1460;
      logic [2:0]  c_cent;
      logic        c_era_end;
      logic [17:0] n;
      logic [8:0]  yq;
      logic [8:0]  yoe;
      logic [8:0]  doy;
      logic [10:0] t5;
      logic [3:0]  mq;
      logic [3:0]  mp;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [9:0]  r3;
      logic [6:0]  r2;
      etf_pkg::date_digits_type d;
   } pipe_type;

   pipe_type pipe_ff [1:NumStages];
   pipe_type pipe_in [1:NumStages];
   logic     valid_ff [1:NumStages];
   logic     advance;

   // first day of each march-based month within the year
   function automatic logic [8:0] mp_start(input logic [3:0] mp);
      logic [8:0] v;
      unique case (mp)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd92;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd153;
         4'd6:    v = 9'd184;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd245;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd306;
         4'd11:   v = 9'd337;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // tens digit of a value below 100
   function automatic logic [3:0] tens_of(input logic [6:0] v);
      logic [14:0] p;
      p = 15'(v) * 15'd205;
      return p[14:11];
   endfunction

   function automatic logic [3:0] ones_of(input logic [6:0] v, input logic [3:0] t);
      logic [6:0] r;
      r = v - 7'(t) * 7'd10;
      return r[3:0];
   endfunction

   always_comb begin
      pipe_type    s;
      logic [56:0] p_h;
      logic [28:0] r_h;
      logic [7:0]  r_h8;
      logic [36:0] p_d;
      logic [16:0] p_m;
      logic [18:0] r_d;
      logic [1:0]  rd;
      logic [9:0]  r_m;
      logic [3:0]  rm;
      logic [19:0] z;
      logic [24:0] p_q;
      logic [16:0] r_q;
      logic [6:0]  q1460;
      logic [27:0] p_y;
      logic [17:0] r_y;
      logic [1:0]  c100;
      logic [17:0] sub;
      logic [14:0] p_mp;
      logic [10:0] r_p;
      logic [3:0]  mon;
      logic [15:0] p_hu;
      logic [3:0]  hu;
      logic [9:0]  r2w;
      logic [8:0]  dday;

      // stage 1: hour estimate from seconds / 3600 = (seconds / 16) / 225
      s         = '0;
      s.cmd     = in_item.command;
      s.x28     = in_item.epoch_seconds[31:4];
      s.lo4     = in_item.epoch_seconds[3:0];
      p_h       = 57'(in_item.epoch_seconds[31:4]) * 57'(M225);
      s.hq      = p_h[56:36];
      pipe_in[1] = s;

      // stage 2: correct hours, seconds within the hour
      s   = pipe_ff[1];
      r_h = 29'(s.x28) - 29'(s.hq) * 29'd225;
      if (r_h[8:0] >= 9'd225) begin
         s.hq = s.hq + 21'd1;
         r_h8 = 8'(r_h[8:0] - 9'd225);
      end else begin
         r_h8 = r_h[7:0];
      end
      s.ms = {r_h8, s.lo4};
      pipe_in[2] = s;

      // stage 3: day and minute estimates
      s     = pipe_ff[2];
      p_d   = 37'(s.hq[20:3]) * 37'(M3);
      s.dq  = p_d[35:20];
      p_m   = 17'(s.ms[11:2]) * 17'(M15);
      s.msq = p_m[15:10];
      pipe_in[3] = s;

      // stage 4: correct days, hours, minutes, seconds
      s   = pipe_ff[3];
      r_d = 19'(s.hq[20:3]) - 19'(s.dq) * 19'd3;
      if (r_d[2:0] >= 3'd3) begin
         s.days = s.dq + 16'd1;
         rd     = 2'(r_d[2:0] - 3'd3);
      end else begin
         s.days = s.dq;
         rd     = r_d[1:0];
      end
      s.hh = {rd, s.hq[2:0]};
      r_m  = 10'(s.ms[11:2]) - 10'(s.msq) * 10'd15;
      if (r_m[4:0] >= 5'd15) begin
         s.mm = s.msq + 6'd1;
         rm   = 4'(r_m[4:0] - 5'd15);
      end else begin
         s.mm = s.msq;
         rm   = r_m[3:0];
      end
      s.ss = {rm, s.ms[1:0]};
      pipe_in[4] = s;

      // stage 5: shift to the march-based era count; only eras four and five occur
      s      = pipe_ff[4];
      z      = 20'(s.days) + EpochShift;
      s.era5 = (z >= Era5Start);
      s.doe  = 18'(z - (s.era5 ? Era5Start : Era4Start));
      pipe_in[5] = s;

      // stage 6: day of era / 1460 estimate, century and era end flags
      s           = pipe_ff[5];
      p_q         = 25'(s.doe[17:2]) * 25'(M365A);
      s.q1460     = p_q[23:17];
      s.c_cent    = 3'(s.doe >= 18'd36524) + 3'(s.doe >= 18'd73048)
                  + 3'(s.doe >= 18'd109572) + 3'(s.doe >= 18'd146096);
      s.c_era_end = (s.doe == 18'd146096);
      pipe_in[6] = s;

      // stage 7: leap-day corrected day count
      s   = pipe_ff[6];
      r_q = 17'(s.doe[17:2]) - 17'(s.q1460) * 17'd365;
      q1460 = (r_q[9:0] >= 10'd365) ? s.q1460 + 7'd1 : s.q1460;
      s.n = s.doe - 18'(q1460) + 18'(s.c_cent) - 18'(s.c_era_end);
      pipe_in[7] = s;

      // stage 8: year of era estimate
      s    = pipe_ff[7];
      p_y  = 28'(s.n) * 28'(M365B);
      s.yq = p_y[26:18];
      pipe_in[8] = s;

      // stage 9: correct year of era
      s     = pipe_ff[8];
      r_y   = s.n - 18'(s.yq) * 18'd365;
      s.yoe = (r_y[9:0] >= 10'd365) ? s.yq + 9'd1 : s.yq;
      pipe_in[9] = s;

      // stage 10: day of year
      s     = pipe_ff[9];
      c100  = 2'(s.yoe >= 9'd100) + 2'(s.yoe >= 9'd200) + 2'(s.yoe >= 9'd300);
      sub   = 18'(s.yoe) * 18'd365 + 18'(s.yoe[8:2]) - 18'(c100);
      s.doy = 9'(s.doe - sub);
      pipe_in[10] = s;

      // stage 11
      s    = pipe_ff[10];
      s.t5 = 11'(s.doy) * 11'd5 + 11'd2;
      pipe_in[11] = s;

      // stage 12: march-based month estimate
      s    = pipe_ff[11];
      p_mp = 15'(s.t5) * 15'(M153);
      s.mq = p_mp[14:11];
      pipe_in[12] = s;

      // stage 13: correct month
      s    = pipe_ff[12];
      r_p  = s.t5 - 11'(s.mq) * 11'd153;
      s.mp = (r_p[8:0] >= 9'd153) ? s.mq + 4'd1 : s.mq;
      pipe_in[13] = s;

      // stage 14: civil day, month and year; january and february count to the next year
      s       = pipe_ff[13];
      dday    = s.doy - mp_start(s.mp) + 9'd1;
      s.day   = dday[4:0];
      mon     = (s.mp < 4'd10) ? s.mp + 4'd3 : s.mp - 4'd9;
      s.month = mon;
      s.year  = 12'(s.yoe) + (s.era5 ? 12'd2000 : 12'd1600) + 12'(mon <= 4'd2);
      pipe_in[14] = s;

      // stage 15: two-digit fields, thousands of the year
      s            = pipe_ff[14];
      s.d.command  = s.cmd;
      s.d.day_hi   = tens_of(7'(s.day));
      s.d.day_lo   = ones_of(7'(s.day), tens_of(7'(s.day)));
      s.d.mon_hi   = tens_of(7'(s.month));
      s.d.mon_lo   = ones_of(7'(s.month), tens_of(7'(s.month)));
      s.d.hr_hi    = tens_of(7'(s.hh));
      s.d.hr_lo    = ones_of(7'(s.hh), tens_of(7'(s.hh)));
      s.d.min_hi   = tens_of(7'(s.mm));
      s.d.min_lo   = ones_of(7'(s.mm), tens_of(7'(s.mm)));
      s.d.sec_hi   = tens_of(7'(s.ss));
      s.d.sec_lo   = ones_of(7'(s.ss), tens_of(7'(s.ss)));
      if (s.year >= 12'd2000) begin
         s.d.yr_3 = 4'd2;
         s.r3     = 10'(s.year - 12'd2000);
      end else begin
         s.d.yr_3 = 4'd1;
         s.r3     = 10'(s.year - 12'd1000);
      end
      pipe_in[15] = s;

      // stage 16: hundreds of the year
      s        = pipe_ff[15];
      p_hu     = 16'(s.r3) * 16'd41;
      hu       = p_hu[15:12];
      s.d.yr_2 = hu;
      r2w      = s.r3 - 10'(hu) * 10'd100;
      s.r2     = r2w[6:0];
      pipe_in[16] = s;

      // stage 17: tens and units of the year
      s        = pipe_ff[16];
      s.d.yr_1 = tens_of(s.r2);
      s.d.yr_0 = ones_of(s.r2, tens_of(s.r2));
      pipe_in[17] = s;
   end

   // whole pipe moves together; it holds only while the last stage waits
   assign advance   = !valid_ff[NumStages] || !out_stall;
   assign in_stall  = !advance;
   assign out_valid = valid_ff[NumStages];
   assign out_item  = pipe_ff[NumStages].d;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NumStages; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[1] <= in_valid;
         for (int k = 2; k <= NumStages; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/etf_char_ser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// etf character serialiser
// walks the digits of one timestamp and emits one ascii character per item,
// loading the next timestamp as the last character leaves
// ---------------------------------------------------------------------------
module etf_char_ser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_stall,
   input  wire etf_pkg::date_digits_type in_item,
   output logic                          out_valid,
   input  wire logic                     out_stall,
   output etf_pkg::rsp_type              out_item
);

   localparam logic [6:0] CharZero  = 7'h30;
   localparam logic [6:0] CharDot   = 7'h2E;
   localparam logic [6:0] CharColon = 7'h3A;
   localparam logic [6:0] CharSpace = 7'h20;

   // character positions within the full format
   localparam logic [4:0] IdxDayHi  = 5'd0;
   localparam logic [4:0] IdxDayLo  = 5'd1;
   localparam logic [4:0] IdxDot1   = 5'd2;
   localparam logic [4:0] IdxMonHi  = 5'd3;
   localparam logic [4:0] IdxMonLo  = 5'd4;
   localparam logic [4:0] IdxDot2   = 5'd5;
   localparam logic [4:0] IdxYr3    = 5'd6;
   localparam logic [4:0] IdxYr2    = 5'd7;
   localparam logic [4:0] IdxYr1    = 5'd8;
   localparam logic [4:0] IdxYr0    = 5'd9;
   localparam logic [4:0] IdxSpace  = 5'd10;
   localparam logic [4:0] IdxHrHi   = 5'd11;
   localparam logic [4:0] IdxHrLo   = 5'd12;
   localparam logic [4:0] IdxColon1 = 5'd13;
   localparam logic [4:0] IdxMinHi  = 5'd14;
   localparam logic [4:0] IdxMinLo  = 5'd15;
   localparam logic [4:0] IdxColon2 = 5'd16;
   localparam logic [4:0] IdxSecHi  = 5'd17;
   localparam logic [4:0] IdxSecLo  = 5'd18;

   logic                     hold_valid_ff;
   etf_pkg::date_digits_type hold_ff;
   logic [4:0]               idx_ff;
   logic                     rsp_valid_ff;
   etf_pkg::rsp_type         rsp_ff;

   logic       out_free;
   logic       emit;
   logic       is_last;
   logic       load;
   logic [6:0] char_sel;

   assign out_free = !rsp_valid_ff || !out_stall;
   assign emit     = out_free && hold_valid_ff;
   assign is_last  = (idx_ff == IdxSecLo);
   assign in_stall = hold_valid_ff && !(emit && is_last);
   assign load     = in_valid && !in_stall;

   always_comb begin
      unique case (idx_ff)
         IdxDayHi:  char_sel = CharZero + 7'(hold_ff.day_hi);
         IdxDayLo:  char_sel = CharZero + 7'(hold_ff.day_lo);
         IdxDot1:   char_sel = CharDot;
         IdxMonHi:  char_sel = CharZero + 7'(hold_ff.mon_hi);
         IdxMonLo:  char_sel = CharZero + 7'(hold_ff.mon_lo);
         IdxDot2:   char_sel = CharDot;
         IdxYr3:    char_sel = CharZero + 7'(hold_ff.yr_3);
         IdxYr2:    char_sel = CharZero + 7'(hold_ff.yr_2);
         IdxYr1:    char_sel = CharZero + 7'(hold_ff.yr_1);
         IdxYr0:    char_sel = CharZero + 7'(hold_ff.yr_0);
         IdxSpace:  char_sel = CharSpace;
         IdxHrHi:   char_sel = CharZero + 7'(hold_ff.hr_hi);
         IdxHrLo:   char_sel = CharZero + 7'(hold_ff.hr_lo);
         IdxColon1: char_sel = CharColon;
         IdxMinHi:  char_sel = CharZero + 7'(hold_ff.min_hi);
         IdxMinLo:  char_sel = CharZero + 7'(hold_ff.min_lo);
         IdxColon2: char_sel = CharColon;
         IdxSecHi:  char_sel = CharZero + 7'(hold_ff.sec_hi);
         IdxSecLo:  char_sel = CharZero + 7'(hold_ff.sec_lo);
         default:   char_sel = CharSpace;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= IdxDayHi;
         rsp_valid_ff  <= 1'b0;
      end else begin
         priority if (load) begin
            hold_valid_ff <= 1'b1;
            // time-only items start at the hour
            idx_ff        <= (in_item.command == etf_pkg::CmdTimeOnly) ? IdxHrHi : IdxDayHi;
         end else if (emit && is_last) begin
            hold_valid_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= idx_ff + 5'd1;
         end
         if (out_free) begin
            rsp_valid_ff <= hold_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= in_item;
      end
      if (out_free) begin
         rsp_ff.char_code <= char_sel;
         rsp_ff.last      <= is_last;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_ff;

endmodule
`default_nettype wire

// ===== design/epoch_timestamp_formatter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// epoch timestamp formatter
// turns unsigned epoch seconds into "DD.MM.YYYY HH:MM:SS" or "HH:MM:SS" text
// ---------------------------------------------------------------------------
// Each request is converted in a 17-stage pipeline that takes a new item every
// cycle while it does not stall, then streamed out one ASCII character per cycle
// while the response port does not stall, with last set on the final character.
// A full timestamp (command 0) is 19 characters and a time-only one (command 1)
// is 8; the serialiser loads the next timestamp as the last character leaves.
// Results pass the pipeline stages, the hold and the response register; up to 17
// further requests are held in the pipeline while characters drain.
module epoch_timestamp_formatter_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire etf_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output etf_pkg::rsp_type       rsp_data
);

   logic                     dig_valid;
   logic                     dig_stall;
   etf_pkg::date_digits_type dig_item;

   etf_date_pipe u_date_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_item   (req_data),
      .out_valid (dig_valid),
      .out_stall (dig_stall),
      .out_item  (dig_item)
   );

   etf_char_ser u_char_ser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dig_valid),
      .in_stall  (dig_stall),
      .in_item   (dig_item),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== verif/epoch_timestamp_formatter_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epoch timestamp formatter testbench
// sends epoch-seconds items in both text modes, works out the expected ascii
// characters with its own civil-date conversion and checks every character
// and its last flag in order, with random gaps on the request port and random
// stalls on the response port
module epoch_timestamp_formatter_top_test;

   localparam byte unsigned ASCII_ZERO  = 8'h30;
   localparam byte unsigned ASCII_DOT   = 8'h2E;
   localparam byte unsigned ASCII_COLON = 8'h3A;
   localparam byte unsigned ASCII_SPACE = 8'h20;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned LAST_FULL_DAY = 49709;
   localparam int unsigned DRAIN_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   etf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   etf_pkg::rsp_type rsp_data;

   etf_pkg::rsp_type expected_chars[$];
   etf_pkg::rsp_type want_char;
   bit          idle_on = 1'b1;
   int unsigned stall_left = 0;
   int unsigned full_count = 0;
   int unsigned time_count = 0;
   int unsigned chars_checked = 0;
   int unsigned failures = 0;

   epoch_timestamp_formatter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short holds, now and then a long one
   function automatic int unsigned hold_length();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(0, 2);
      end
      return $urandom_range(15, 40);
   endfunction

   // day, month, year and time of day, then the characters of the chosen mode
   function automatic void predict_timestamp(input etf_pkg::req_type item);
      int unsigned second, minute, hour, total_min, total_hr;
      int unsigned days, era, doe, yoe, year, doy, mp, day, month;
      byte unsigned text[$];
      second    = item.epoch_seconds % 60;
      total_min = item.epoch_seconds / 60;
      minute    = total_min % 60;
      total_hr  = total_min / 60;
      hour      = total_hr % 24;
      // civil calendar counted from march so the leap day falls at year end
      days  = total_hr / 24 + 719468;
      era   = days / 146097;
      doe   = days - era * 146097;
      yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      year  = yoe + era * 400;
      doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp    = (5 * doy + 2) / 153;
      day   = doy - (153 * mp + 2) / 5 + 1;
      month = (mp < 10) ? mp + 3 : mp - 9;
      if (month <= 2) begin
         year++;
      end
      if (item.command == etf_pkg::CmdDateTime) begin
         text.push_back(ASCII_ZERO + (day / 10) % 10);
         text.push_back(ASCII_ZERO + day % 10);
         text.push_back(ASCII_DOT);
         text.push_back(ASCII_ZERO + (month / 10) % 10);
         text.push_back(ASCII_ZERO + month % 10);
         text.push_back(ASCII_DOT);
         text.push_back(ASCII_ZERO + (year / 1000) % 10);
         text.push_back(ASCII_ZERO + (year / 100) % 10);
         text.push_back(ASCII_ZERO + (year / 10) % 10);
         text.push_back(ASCII_ZERO + year % 10);
         text.push_back(ASCII_SPACE);
      end
      text.push_back(ASCII_ZERO + (hour / 10) % 10);
      text.push_back(ASCII_ZERO + hour % 10);
      text.push_back(ASCII_COLON);
      text.push_back(ASCII_ZERO + (minute / 10) % 10);
      text.push_back(ASCII_ZERO + minute % 10);
      text.push_back(ASCII_COLON);
      text.push_back(ASCII_ZERO + (second / 10) % 10);
      text.push_back(ASCII_ZERO + second % 10);
      foreach (text[i]) begin
         expected_chars.push_back('{char_code: text[i][6:0], last: (i == text.size() - 1)});
      end
   endfunction

   // valid is left high when the next item follows with no gap
   task automatic send_timestamp(input bit cmd, input logic [31:0] secs);
      etf_pkg::req_type item;
      int unsigned      gap;
      item.command       = cmd;
      item.epoch_seconds = secs;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_timestamp(item);
      if (cmd == etf_pkg::CmdDateTime) begin
         full_count++;
      end else begin
         time_count++;
      end
      gap = 0;
      if (idle_on && $urandom_range(0, 99) >= 50) begin
         gap = hold_length() + 1;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 25) begin
         rsp_stall  <= 1'b1;
         stall_left <= hold_length();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected character 0x%02h last %0b", rsp_data.char_code, rsp_data.last);
            failures++;
         end else begin
            want_char = expected_chars.pop_front();
            chars_checked++;
            if (rsp_data.char_code !== want_char.char_code) begin
               $error("char_code: expected 0x%02h, got 0x%02h",
                      want_char.char_code, rsp_data.char_code);
               failures++;
            end
            if (rsp_data.last !== want_char.last) begin
               $error("last: expected %0b, got %0b", want_char.last, rsp_data.last);
               failures++;
            end
         end
      end
   end

   // range ends, the 2038 sign boundary, bit patterns and time-only items at day edges and noon
   task automatic test_epoch_extremes();
      send_timestamp(etf_pkg::CmdDateTime, 32'd0);
      send_timestamp(etf_pkg::CmdTimeOnly, 32'd0);
      send_timestamp(etf_pkg::CmdDateTime, 32'hFFFF_FFFF);
      send_timestamp(etf_pkg::CmdTimeOnly, 32'hFFFF_FFFF);
      send_timestamp(etf_pkg::CmdDateTime, 32'h7FFF_FFFF);
      send_timestamp(etf_pkg::CmdDateTime, 32'h8000_0000);
      send_timestamp(etf_pkg::CmdTimeOnly, 32'd86399);
      send_timestamp(etf_pkg::CmdTimeOnly, 32'd43200);
      send_timestamp(etf_pkg::CmdDateTime, 32'hAAAA_AAAA);
      send_timestamp(etf_pkg::CmdDateTime, 32'h5555_5555);
   endtask

   // leap days, century rules, year end and the january/february year bump
   task automatic test_calendar_edges();
      send_timestamp(etf_pkg::CmdDateTime, 32'd68169600);
      send_timestamp(etf_pkg::CmdDateTime, 32'd946684799);
      send_timestamp(etf_pkg::CmdDateTime, 32'd946684800);
      send_timestamp(etf_pkg::CmdDateTime, 32'd951782400);
      send_timestamp(etf_pkg::CmdDateTime, 32'd951868799);
      send_timestamp(etf_pkg::CmdDateTime, 32'd951868800);
      send_timestamp(etf_pkg::CmdDateTime, 32'd4102444800);
      send_timestamp(etf_pkg::CmdDateTime, 32'd4107542399);
      send_timestamp(etf_pkg::CmdDateTime, 32'd4107542400);
      send_timestamp(etf_pkg::CmdDateTime, 32'd2678399);
      send_timestamp(etf_pkg::CmdTimeOnly, 32'd4107542399);
   endtask

   task automatic test_random_timestamps(input int unsigned count);
      logic [31:0] secs;
      int unsigned pick;
      for (int unsigned i = 0; i < count; i++) begin
         // a stretch at full pressure with no gaps or stalls
         if (i == count / 2) begin
            idle_on <= 1'b0;
         end else if (i == count / 2 + 25) begin
            idle_on <= 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            secs = $urandom;
         end else if (pick < 85) begin
            secs = $urandom_range(0, LAST_FULL_DAY) * SECS_PER_DAY;
            if ($urandom_range(0, 1) == 1) begin
               secs = secs + SECS_PER_DAY - 1;
            end
         end else begin
            secs = 32'hFFFF_FFFF - $urandom_range(0, 4000000);
         end
         send_timestamp($urandom_range(0, 1) == 1 ? etf_pkg::CmdTimeOnly : etf_pkg::CmdDateTime,
                        secs);
      end
   endtask

   task automatic drain_chars();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_chars.size() != 0) begin
         $error("%0d expected characters never arrived", expected_chars.size());
         failures++;
         expected_chars.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_epoch_extremes();
      test_calendar_edges();
      test_random_timestamps(109);
      drain_chars();
      $display("sent %0d full date-time and %0d time-only timestamps", full_count, time_count);
      $display("checked %0d characters under random gaps and stalls", chars_checked);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timed out with %0d characters outstanding", expected_chars.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
